// ===== hw/rtl/bca_pkg.sv =====
// Shared types and constants for the bitmap chunk allocator.
// Used by bca_ctrl, bca_dp and bitmap_chunk_allocator_top; depends on nothing.
package bca_pkg;

  localparam int MAX_CHUNKS    = 1024;
  localparam int MAP_WORD_BITS = 64;
  localparam int MAP_WORDS     = (MAX_CHUNKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

  localparam int ADDR_W   = 48;
  localparam int SIZE_W   = 16;
  localparam int CNT_W    = 11;
  localparam int IDX_W    = 10;
  localparam int BIT_W    = $clog2(MAP_WORD_BITS);
  localparam int WPTR_W   = $clog2(MAP_WORDS);
  localparam int NWORDS_W = WPTR_W + 1;
  localparam int DIV_W    = SIZE_W + CNT_W;
  localparam int DCNT_W   = $clog2(IDX_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd2;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_DOUBLE  = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    scan_start;
    logic    scan_next;
    logic    rd_scan;
    logic    rd_free;
    logic    alloc_take;
    logic    mul_idx;
    logic    add_base;
    logic    free_prep;
    logic    div_start;
    logic    div_step;
    logic    free_set;
    logic    clear_all;
    logic    set_status;
    status_t status_code;
    logic    load_out;
  } bca_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_kind;
    logic       alloc_ok;
    logic       hit;
    logic       scan_last;
    logic       out_range;
    logic       div_last;
    logic       bit_free;
    logic       out_ready;
  } bca_stat_t;

endpackage

// ===== hw/rtl/bca_ctrl.sv =====
// Request sequencer of the bitmap chunk allocator.
// Depends on bca_pkg; drives the command struct of bca_dp.
module bca_ctrl import bca_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  bca_stat_t stat,
  output bca_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_A_READ,
    S_A_CHECK,
    S_A_MUL,
    S_A_ADD,
    S_F_RANGE,
    S_F_DIV,
    S_F_READ,
    S_F_CHECK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.req_kind)
          REQ_ALLOC: begin
            if (stat.alloc_ok) begin
              cmd.scan_start = 1'b1;
              state_next     = S_A_READ;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
              state_next      = S_FINISH;
            end
          end
          REQ_FREE: begin
            cmd.free_prep = 1'b1;
            state_next    = S_F_RANGE;
          end
          REQ_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_next    = S_FINISH;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_A_READ: begin
        cmd.rd_scan = 1'b1;
        state_next  = S_A_CHECK;
      end
      S_A_CHECK: begin
        if (stat.hit) begin
          cmd.alloc_take = 1'b1;
          state_next     = S_A_MUL;
        end else if (stat.scan_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_FULL;
          state_next      = S_FINISH;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_A_READ;
        end
      end
      S_A_MUL: begin
        cmd.mul_idx = 1'b1;
        state_next  = S_A_ADD;
      end
      S_A_ADD: begin
        cmd.add_base = 1'b1;
        state_next   = S_FINISH;
      end
      S_F_RANGE: begin
        if (stat.out_range) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_OUTSIDE;
          state_next      = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_F_DIV;
        end
      end
      S_F_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_F_READ;
        end
      end
      S_F_READ: begin
        cmd.rd_free = 1'b1;
        state_next  = S_F_CHECK;
      end
      S_F_CHECK: begin
        if (stat.bit_free) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_DOUBLE;
        end else begin
          cmd.free_set = 1'b1;
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/bca_dp.sv =====
// Datapath of the bitmap chunk allocator: configuration, free map memory,
// word scan, range check, divider, address multiply and the result register.
// Depends on bca_pkg; sequenced by bca_ctrl.
module bca_dp import bca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic [1:0]           req_type,
  input  logic [ADDR_W-1:0]    free_address,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [1:0]           status,
  output logic [IDX_W-1:0]     chunk_index,
  output logic [ADDR_W-1:0]    chunk_address,
  output logic [CNT_W-1:0]     free_total,
  input  bca_cmd_t             cmd,
  output bca_stat_t            stat
);

  // Configuration and allocator state.
  logic [CNT_W-1:0]  eff_count;
  logic [SIZE_W-1:0] chunk_bytes;
  logic [ADDR_W-1:0] pool_base;
  logic [CNT_W-1:0]  free_counter;
  logic [DIV_W-1:0]  pool_limit;

  // Free map memory; an entry whose valid bit is low reads as all free.
  logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]     map_valid;
  logic [MAP_WORD_BITS-1:0] rd_data;
  logic                     rd_valid;

  // Request and working registers.
  logic [1:0]          req_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [ADDR_W-1:0]   diff;
  logic                borrow;
  logic [WPTR_W-1:0]   ptr;
  logic [NWORDS_W-1:0] iter;
  logic [DIV_W-1:0]    rem;
  logic [DIV_W-1:0]    dsor;
  logic [IDX_W-1:0]    quo;
  logic [DCNT_W-1:0]   div_cnt;
  logic [SIZE_W+IDX_W-1:0] prod;
  status_t             res_status;
  logic [IDX_W-1:0]    res_idx;
  logic [ADDR_W-1:0]   res_addr;

  // Combinational helpers.
  logic [SIZE_W-1:0]        size;
  logic [CNT_W-1:0]         new_count;
  logic [CNT_W-1:0]         new_eff;
  logic [CNT_W-1:0]         words_sum;
  logic [NWORDS_W-1:0]      words;
  logic [CNT_W-1:0]         used;
  logic [CNT_W-1:0]         left;
  logic                     left_full;
  logic [MAP_WORD_BITS-1:0] cur_word;
  logic [MAP_WORD_BITS-1:0] limit_mask;
  logic [MAP_WORD_BITS-1:0] cand;
  logic [MAP_WORD_BITS-1:0] lowest;
  logic [BIT_W-1:0]         low_bit;
  logic [MAP_WORD_BITS-1:0] free_onehot;
  logic [DIV_W:0]           trial;
  logic [ADDR_W:0]          diff_full;
  logic [WPTR_W-1:0]        rd_addr;
  logic                     mem_we;
  logic [WPTR_W-1:0]        wr_addr;
  logic [MAP_WORD_BITS-1:0] wr_data;
  logic                     out_ready;

  assign size      = (chunk_bytes == '0) ? SIZE_W'(1) : chunk_bytes;
  assign new_count = cfg_data[CNT_W-1:0];
  assign new_eff   = (new_count > CNT_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : new_count;

  assign words_sum = eff_count + CNT_W'(MAP_WORD_BITS - 1);
  assign words     = words_sum[BIT_W +: NWORDS_W];
  assign used      = (eff_count > free_counter) ? (eff_count - free_counter) : '0;

  // Bits of the current word that lie below the chunk count.
  assign left      = eff_count - CNT_W'({ptr, {BIT_W{1'b0}}});
  assign left_full = (left[CNT_W-1:BIT_W] != '0);
  assign cur_word  = rd_valid ? rd_data : '1;

  always_comb begin
    limit_mask  = '0;
    low_bit     = '0;
    free_onehot = '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      limit_mask[b]  = left_full || (BIT_W'(b) < left[BIT_W-1:0]);
      free_onehot[b] = (res_idx[BIT_W-1:0] == BIT_W'(b));
    end
    cand   = cur_word & limit_mask;
    lowest = cand & (~cand + MAP_WORD_BITS'(1));
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      low_bit = low_bit | (lowest[b] ? BIT_W'(b) : BIT_W'(0));
    end
  end

  assign trial     = {1'b0, rem} - {1'b0, dsor};
  assign diff_full = {1'b0, addr_q} - {1'b0, pool_base};
  assign out_ready = !rsp_valid || !rsp_stall;

  assign rd_addr = cmd.rd_scan ? ptr : quo[IDX_W-1:BIT_W];
  assign mem_we  = cmd.alloc_take || cmd.free_set;
  assign wr_addr = cmd.alloc_take ? ptr : res_idx[IDX_W-1:BIT_W];
  assign wr_data = cmd.alloc_take ? (cur_word & ~lowest) : (cur_word | free_onehot);

  assign stat.req_kind  = req_q;
  assign stat.alloc_ok  = (free_counter != '0) && (eff_count != '0);
  assign stat.hit       = (cand != '0);
  assign stat.scan_last = (iter == words - NWORDS_W'(1));
  assign stat.out_range = borrow || (eff_count == '0) || (diff >= ADDR_W'(pool_limit));
  assign stat.div_last  = (div_cnt == '0);
  assign stat.bit_free  = cur_word[res_idx[BIT_W-1:0]];
  assign stat.out_ready = out_ready;

  // Map memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_scan || cmd.rd_free) begin
      rd_data  <= map_mem[rd_addr];
      rd_valid <= map_valid[rd_addr];
    end
  end

  // Configuration, counters and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_count    <= CNT_W'(MAX_CHUNKS);
      chunk_bytes  <= SIZE_W'(64);
      pool_base    <= '0;
      free_counter <= CNT_W'(MAX_CHUNKS);
      map_valid    <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_CHUNK_COUNT: begin
            eff_count    <= new_eff;
            free_counter <= new_eff;
            map_valid    <= '0;
          end
          CFG_CHUNK_BYTES: chunk_bytes <= cfg_data[SIZE_W-1:0];
          CFG_POOL_BASE:   pool_base   <= cfg_data;
          default: ;
        endcase
      end else if (cmd.clear_all) begin
        free_counter <= eff_count;
        map_valid    <= '0;
      end else begin
        if (cmd.alloc_take) begin
          free_counter <= free_counter - CNT_W'(1);
        end
        if (cmd.free_set && free_counter != '1) begin
          free_counter <= free_counter + CNT_W'(1);
        end
        if (mem_we) begin
          map_valid[wr_addr] <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers of one request.
  always_ff @(posedge clk) begin
    pool_limit <= DIV_W'(size) * DIV_W'(eff_count);
    if (cmd.accept) begin
      req_q      <= req_type;
      addr_q     <= free_address;
      res_status <= ST_OK;
      res_idx    <= '0;
      res_addr   <= '0;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status_code;
    end
    if (cmd.scan_start) begin
      ptr  <= used[IDX_W-1:BIT_W];
      iter <= '0;
    end
    if (cmd.scan_next) begin
      ptr  <= (NWORDS_W'(ptr) == words - NWORDS_W'(1)) ? '0 : ptr + WPTR_W'(1);
      iter <= iter + NWORDS_W'(1);
    end
    if (cmd.alloc_take) begin
      res_idx <= {ptr, low_bit};
    end
    if (cmd.mul_idx) begin
      prod <= (SIZE_W+IDX_W)'(size) * (SIZE_W+IDX_W)'(res_idx);
    end
    if (cmd.add_base) begin
      res_addr <= pool_base + ADDR_W'(prod);
    end
    if (cmd.free_prep) begin
      diff   <= diff_full[ADDR_W-1:0];
      borrow <= diff_full[ADDR_W];
    end
    // Restoring division; the range check keeps the quotient below the count.
    if (cmd.div_start) begin
      rem     <= diff[DIV_W-1:0];
      dsor    <= DIV_W'(size) << (IDX_W - 1);
      quo     <= '0;
      div_cnt <= DCNT_W'(IDX_W - 1);
    end
    if (cmd.div_step) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
      end
      quo     <= {quo[IDX_W-2:0], !trial[DIV_W]};
      dsor    <= dsor >> 1;
      div_cnt <= div_cnt - DCNT_W'(1);
    end
    if (cmd.rd_free) begin
      res_idx <= quo;
    end
    if (cmd.load_out) begin
      status        <= res_status;
      chunk_index   <= res_idx;
      chunk_address <= res_addr;
      free_total    <= free_counter;
    end
  end

endmodule

// ===== hw/rtl/bitmap_chunk_allocator_top.sv =====
// Bitmap chunk allocator: one chunk per request. Allocate reads and checks map words
// (1 to 16) in turn, then multiplies and adds into the result register, or stops when
// the pool is full; free checks the range, runs the ten-step divider, reads and checks
// the map word, or stops for an outside address; clear and the spare code just decode.
// One request is worked at a time; the next is accepted while the result waits.
// Synchronous reset restores a 1024-chunk pool of 64-byte chunks at base 0, all free.
module bitmap_chunk_allocator_top import bca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [1:0]           req_type,
  input  logic [ADDR_W-1:0]    free_address,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [1:0]           status,
  output logic [IDX_W-1:0]     chunk_index,
  output logic [ADDR_W-1:0]    chunk_address,
  output logic [CNT_W-1:0]     free_total
);

  bca_cmd_t  cmd;
  bca_stat_t stat;

  bca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bca_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .free_address  (free_address),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .chunk_index   (chunk_index),
    .chunk_address (chunk_address),
    .free_total    (free_total),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
